@@ src/bbpf_pkg.sv @@
// ----------------------------------------------------------------------------
// bbpf_pkg: shared types and constants
// Actions, render modes, register indexes and the command word that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbpf_pkg;

  localparam int unsigned PAGE_BYTES      = 32'hA000;
  localparam int unsigned SMALL_W         = 160;
  localparam int unsigned SMALL_H         = 128;
  localparam int unsigned PAL_DEPTH       = 256;
  localparam int unsigned MOSAIC_MAX      = 16;
  localparam int unsigned CFG_DATA_W      = 8;

  typedef enum logic [1:0] {
    ACT_VWRITE = 2'd0,
    ACT_PWRITE = 2'd1,
    ACT_RENDER = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    MODE_DIRECT = 2'd0,
    MODE_PAL    = 2'd1,
    MODE_SMALL  = 2'd2,
    MODE_BLANK  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE     = 2'd0,
    REG_PAGE     = 2'd1,
    REG_MOSAIC   = 2'd2,
    REG_MOSAIC_W = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    CMD_VWRITE = 2'd0,
    CMD_PWRITE = 2'd1,
    CMD_RENDER = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e        kind;
    logic [15:0] vidx;      // video halfword index, or palette index in [7:0]
    logic [15:0] data;      // write data
    logic [7:0]  x;
    logic        vzero;     // skip the video read, use zero
    logic        pal_mode;  // colour comes from the palette
    logic        odd;       // high byte of the halfword is the palette index
    logic        transp;
  } cmd_t;

endpackage

@@ src/bbpf_if.sv @@
// ----------------------------------------------------------------------------
// bbpf_if: channel interfaces
// Input item, result and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bbpf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] address;
  logic [15:0] write_data;
  logic [7:0]  pixel_x;
  logic [7:0]  scan_line;
  logic [3:0]  mosaic_line_offset;

  modport source (output valid, action, address, write_data, pixel_x, scan_line,
                  mosaic_line_offset, input ready);
  modport sink (input valid, action, address, write_data, pixel_x, scan_line,
                mosaic_line_offset, output ready);
endinterface

interface bbpf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_x;
  logic [15:0] colour;
  logic        transparent;

  modport source (output valid, out_x, colour, transparent, input ready);
  modport sink (input valid, out_x, colour, transparent, output ready);
endinterface

interface bbpf_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/bitmap_background_pixel_fetch_core.sv @@
// ----------------------------------------------------------------------------
// bitmap_background_pixel_fetch_core: bitmap background pixel fetch
// Video memory and palette with a pixel fetch pipeline for bitmap modes.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one word per item: a video halfword write, a palette write
//   or a render request for one pixel. Writes produce no result; a render
//   request produces one word on out_o with its column, colour and the
//   transparent flag.
//   cfg_i writes render mode, frame page, mosaic enable and mosaic width by
//   register index; it is always ready, and the user must write it only while
//   idle: the block itself does not enforce this. Throughput: one item per
//   cycle while out_o is ready. The front end decodes and computes the
//   halfword index in the accepting cycle and pushes into a four-entry queue;
//   the back end runs video RAM, palette RAM and the result register as three
//   stages. When out_o stalls, the whole back end holds and the queue fills;
//   in_i drops ready only once the queue is full, and nothing is lost.
//   Reset zeroes mode, page, mosaic enable, mosaic counter and all pipeline
//   valids and sets mosaic width to one. Memory is undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_background_pixel_fetch_core import bbpf_pkg::*; #(
  parameter int unsigned VIDEO_HALFWORDS = 49152,
  parameter int unsigned LINE_PIXELS     = 240
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bbpf_in_if.sink    in_i,
  bbpf_cfg_if.sink   cfg_i,
  bbpf_out_if.source out_o
);

  logic push, pop, fifo_ready, fifo_valid;
  cmd_t push_cmd, pop_cmd;

  bbpf_front #(
    .VIDEO_HALFWORDS (VIDEO_HALFWORDS),
    .LINE_PIXELS     (LINE_PIXELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .fifo_ready_i (fifo_ready)
  );

  bbpf_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (4)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .ready_o     (fifo_ready),
    .pop_i       (pop),
    .valid_o     (fifo_valid),
    .pop_data_o  (pop_cmd)
  );

  bbpf_back #(
    .VIDEO_HALFWORDS (VIDEO_HALFWORDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

@@ src/bbpf_ram.sv @@
// ----------------------------------------------------------------------------
// bbpf_ram: single-port RAM
// One access per cycle when enabled; read data registered and held otherwise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbpf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/bbpf_fifo.sv @@
// ----------------------------------------------------------------------------
// bbpf_fifo: command queue
// Short queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbpf_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o    = (cnt_q != CntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/bbpf_front.sv @@
// ----------------------------------------------------------------------------
// bbpf_front: item decode and address generation
// Holds the registers and the mosaic counter, turns each word into a command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbpf_front import bbpf_pkg::*; #(
  parameter int unsigned VIDEO_HALFWORDS = 49152,
  parameter int unsigned LINE_PIXELS     = 240
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bbpf_in_if.sink     in_i,
  bbpf_cfg_if.sink    cfg_i,
  output logic        push_o,
  output cmd_t        cmd_o,
  input  logic        fifo_ready_i
);

  logic [1:0]  mode_q;
  logic        page_q, mosaic_q;
  logic [4:0]  mosaic_w_q;
  logic [3:0]  cnt_q, cnt_d;

  logic        accept;
  action_e     act;
  logic [3:0]  cnt_eff;
  logic [7:0]  line, sx;
  logic [8:0]  mul_k;
  logic [16:0] prod, offs, sum, idx;
  logic        oob, in_frame;
  logic [4:0]  w_eff, cnt_next;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = fifo_ready_i;
  assign accept      = in_i.valid && fifo_ready_i;
  assign act         = action_e'(in_i.action);

  // Source line and column
  always_comb begin
    cnt_eff = (in_i.pixel_x == '0) ? '0 : cnt_q;
    line    = in_i.scan_line;
    sx      = in_i.pixel_x;
    if (mosaic_q) begin
      line = ({4'd0, in_i.mosaic_line_offset} > in_i.scan_line) ? '0 :
             in_i.scan_line - {4'd0, in_i.mosaic_line_offset};
      sx   = ({4'd0, cnt_eff} > in_i.pixel_x) ? '0 : in_i.pixel_x - {4'd0, cnt_eff};
    end
  end

  // Halfword index: byte address in paletted mode, halfwords otherwise
  always_comb begin
    mul_k = (mode_e'(mode_q) == MODE_SMALL) ? 9'(SMALL_W) : 9'(LINE_PIXELS);
    prod  = 17'(line) * 17'(mul_k);
    unique case (mode_e'(mode_q))
      MODE_PAL:   offs = page_q ? 17'(PAGE_BYTES) : '0;
      MODE_SMALL: offs = page_q ? 17'(PAGE_BYTES / 2) : '0;
      default:    offs = '0;
    endcase
    sum      = offs + prod + 17'(sx);
    idx      = (mode_e'(mode_q) == MODE_PAL) ? {1'b0, sum[16:1]} : sum;
    oob      = (idx >= 17'(VIDEO_HALFWORDS));
    in_frame = (sx < 8'(SMALL_W)) && (line < 8'(SMALL_H));
  end

  always_comb begin
    cmd_o.kind     = CMD_RENDER;
    cmd_o.vidx     = in_i.address;
    cmd_o.data     = in_i.write_data;
    cmd_o.x        = in_i.pixel_x;
    cmd_o.vzero    = 1'b0;
    cmd_o.pal_mode = 1'b0;
    cmd_o.odd      = 1'b0;
    cmd_o.transp   = 1'b0;
    push_o         = 1'b0;
    unique case (act)
      ACT_VWRITE: begin
        cmd_o.kind = CMD_VWRITE;
        push_o     = accept && (17'(in_i.address) < 17'(VIDEO_HALFWORDS));
      end
      ACT_PWRITE: begin
        cmd_o.kind = CMD_PWRITE;
        push_o     = accept && (17'(in_i.address) < 17'(PAL_DEPTH));
      end
      ACT_RENDER: begin
        push_o     = accept;
        cmd_o.vidx = idx[15:0];
        unique case (mode_e'(mode_q))
          MODE_DIRECT: cmd_o.vzero = oob;
          MODE_PAL: begin
            cmd_o.vzero    = oob;
            cmd_o.pal_mode = 1'b1;
            cmd_o.odd      = sum[0];
          end
          MODE_SMALL: begin
            cmd_o.vzero  = oob || !in_frame;
            cmd_o.transp = !in_frame;
          end
          MODE_BLANK: begin
            cmd_o.vzero  = 1'b1;
            cmd_o.transp = 1'b1;
          end
        endcase
      end
      ACT_NONE: push_o = 1'b0;
    endcase
  end

  // Mosaic counter: advance per rendered pixel, wrap at the clamped width
  always_comb begin
    w_eff    = (mosaic_w_q == '0) ? 5'd1 :
               (mosaic_w_q > 5'(MOSAIC_MAX)) ? 5'(MOSAIC_MAX) : mosaic_w_q;
    cnt_next = {1'b0, cnt_eff} + 5'd1;
    cnt_d    = cnt_q;
    if (accept && (act == ACT_RENDER)) begin
      if (mosaic_q) begin
        cnt_d = (cnt_next >= w_eff) ? '0 : cnt_next[3:0];
      end else begin
        cnt_d = cnt_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= '0;
      page_q     <= 1'b0;
      mosaic_q   <= 1'b0;
      mosaic_w_q <= 5'd1;
      cnt_q      <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_i.valid) begin
        unique case (reg_e'(cfg_i.index))
          REG_MODE:     mode_q     <= cfg_i.data[1:0];
          REG_PAGE:     page_q     <= cfg_i.data[0];
          REG_MOSAIC:   mosaic_q   <= cfg_i.data[0];
          REG_MOSAIC_W: mosaic_w_q <= cfg_i.data[4:0];
        endcase
      end
    end
  end

endmodule

@@ src/bbpf_back.sv @@
// ----------------------------------------------------------------------------
// bbpf_back: memory access pipeline
// Video read or write, palette read or write, then the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbpf_back import bbpf_pkg::*; #(
  parameter int unsigned VIDEO_HALFWORDS = 49152
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  bbpf_out_if.source  out_o
);

  localparam int unsigned VAddrW = $clog2(VIDEO_HALFWORDS);
  localparam int unsigned PAddrW = $clog2(PAL_DEPTH);

  logic        en;
  logic        vram_en, vram_we;
  logic [15:0] vram_rdata;
  logic        pram_en;
  logic [15:0] pram_rdata;
  logic [15:0] hw;
  logic [7:0]  pal_idx;

  logic        s1_valid_q, s1_pwr_q, s1_vzero_q, s1_pal_q, s1_odd_q, s1_transp_q;
  logic [7:0]  s1_x_q, s1_pidx_q;
  logic [15:0] s1_pdata_q;

  logic        s2_valid_q, s2_pal_q, s2_transp_q;
  logic [7:0]  s2_x_q;
  logic [15:0] s2_direct_q;

  logic        out_valid_q, out_transp_q;
  logic [7:0]  out_x_q;
  logic [15:0] out_colour_q;

  // Whole pipeline advances together; hold everything while the result waits
  assign en    = !out_valid_q || out_o.ready;
  assign pop_o = cmd_valid_i && en;

  assign vram_we = (cmd_i.kind == CMD_VWRITE);
  assign vram_en = pop_o && (vram_we || ((cmd_i.kind == CMD_RENDER) && !cmd_i.vzero));

  bbpf_ram #(
    .Width (16),
    .Depth (VIDEO_HALFWORDS)
  ) u_video_ram (
    .clk_i   (clk_i),
    .en_i    (vram_en),
    .we_i    (vram_we),
    .addr_i  (cmd_i.vidx[VAddrW-1:0]),
    .wdata_i (cmd_i.data),
    .rdata_o (vram_rdata)
  );

  // Palette writes happen in stage 1 so they stay in order with palette reads
  assign hw      = s1_vzero_q ? '0 : vram_rdata;
  assign pal_idx = s1_pwr_q ? s1_pidx_q : (s1_odd_q ? hw[15:8] : hw[7:0]);
  assign pram_en = en && (s1_pwr_q || (s1_valid_q && s1_pal_q));

  bbpf_ram #(
    .Width (16),
    .Depth (PAL_DEPTH)
  ) u_palette_ram (
    .clk_i   (clk_i),
    .en_i    (pram_en),
    .we_i    (s1_pwr_q),
    .addr_i  (pal_idx[PAddrW-1:0]),
    .wdata_i (s1_pdata_q),
    .rdata_o (pram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_pwr_q    <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= pop_o && (cmd_i.kind == CMD_RENDER);
      s1_pwr_q    <= pop_o && (cmd_i.kind == CMD_PWRITE);
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_vzero_q   <= cmd_i.vzero;
      s1_pal_q     <= cmd_i.pal_mode;
      s1_odd_q     <= cmd_i.odd;
      s1_transp_q  <= cmd_i.transp;
      s1_x_q       <= cmd_i.x;
      s1_pidx_q    <= cmd_i.vidx[7:0];
      s1_pdata_q   <= cmd_i.data;
      s2_pal_q     <= s1_pal_q;
      s2_transp_q  <= s1_transp_q;
      s2_x_q       <= s1_x_q;
      s2_direct_q  <= hw;
      out_x_q      <= s2_x_q;
      out_transp_q <= s2_transp_q;
      out_colour_q <= s2_pal_q ? pram_rdata : s2_direct_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_x       = out_x_q;
  assign out_o.colour      = out_colour_q;
  assign out_o.transparent = out_transp_q;

endmodule

@@ tb/sv/bbpf_colour_checker.sv @@
// ----------------------------------------------------------------------------
// bbpf_colour_checker: colour prediction and compare for the pixel fetch
// Watches the item, register and result channels, keeps its own copy of
// video memory, palette, registers and column counter, and compares each
// accepted result word with the oldest predicted pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbpf_colour_checker import bbpf_pkg::*; #(
  parameter int unsigned VIDEO_HALFWORDS = 49152,
  parameter int unsigned LINE_PIXELS     = 240
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bbpf_in_if          pix_in_i,
  bbpf_cfg_if         reg_wr_i,
  bbpf_out_if         pix_out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [7:0]  x;
    logic [15:0] colour;
    logic        transparent;
  } pixel_word_t;

  logic [15:0] vram    [VIDEO_HALFWORDS];
  logic [15:0] palette [PAL_DEPTH];
  pixel_word_t expected_pixels [$];

  mode_e       mode_q;
  logic        page_q;
  logic        mosaic_q;
  logic [4:0]  width_q;
  logic [3:0]  col_count;
  int unsigned mismatches;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t checker: %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic logic [15:0] vram_read(input int unsigned slot);
    if (slot >= VIDEO_HALFWORDS) begin
      return 16'h0000;
    end
    return vram[slot];
  endfunction

  function automatic pixel_word_t fetch_pixel(input logic [7:0] px, input logic [7:0] sl,
                                              input logic [3:0] loff);
    pixel_word_t w;
    int unsigned line, sx, byte_addr, span, nxt;
    logic [15:0] hw;
    if (px == 8'd0) begin
      col_count = 4'd0;
    end
    line = sl;
    sx   = px;
    if (mosaic_q) begin
      line = (loff > sl) ? 0 : sl - loff;
      sx   = (col_count > px) ? 0 : px - col_count;
    end
    w.x           = px;
    w.colour      = 16'h0000;
    w.transparent = 1'b0;
    case (mode_q)
      MODE_DIRECT: begin
        w.colour = vram_read(line * LINE_PIXELS + sx);
      end
      MODE_PAL: begin
        byte_addr = page_q * PAGE_BYTES + line * LINE_PIXELS + sx;
        hw        = vram_read(byte_addr >> 1);
        w.colour  = palette[byte_addr[0] ? hw[15:8] : hw[7:0]];
      end
      MODE_SMALL: begin
        if (sx < SMALL_W && line < SMALL_H) begin
          byte_addr = page_q * PAGE_BYTES + line * SMALL_W * 2 + sx * 2;
          w.colour  = vram_read(byte_addr >> 1);
        end else begin
          w.transparent = 1'b1;
        end
      end
      default: begin
        w.transparent = 1'b1;
      end
    endcase
    // advance the column counter after the fetch, clamp the width to 1..16
    if (mosaic_q) begin
      span = (width_q == 5'd0) ? 1 : (width_q > MOSAIC_MAX) ? MOSAIC_MAX : width_q;
      nxt  = col_count + 1;
      col_count = (nxt >= span) ? 4'd0 : nxt[3:0];
    end
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pixel_word_t want;
    if (!rst_ni) begin
      mode_q    = MODE_DIRECT;
      page_q    = 1'b0;
      mosaic_q  = 1'b0;
      width_q   = 5'd1;
      col_count = 4'd0;
      expected_pixels.delete();
      pending_o <= 0;
    end else begin
      if (reg_wr_i.valid && reg_wr_i.ready) begin
        case (reg_e'(reg_wr_i.index))
          REG_MODE:     mode_q   = mode_e'(reg_wr_i.data[1:0]);
          REG_PAGE:     page_q   = reg_wr_i.data[0];
          REG_MOSAIC:   mosaic_q = reg_wr_i.data[0];
          REG_MOSAIC_W: width_q  = reg_wr_i.data[4:0];
          default: ;
        endcase
      end
      if (pix_in_i.valid && pix_in_i.ready) begin
        case (action_e'(pix_in_i.action))
          ACT_VWRITE: begin
            if (pix_in_i.address < VIDEO_HALFWORDS) begin
              vram[pix_in_i.address] = pix_in_i.write_data;
            end
          end
          ACT_PWRITE: begin
            if (pix_in_i.address < PAL_DEPTH) begin
              palette[pix_in_i.address[7:0]] = pix_in_i.write_data;
            end
          end
          ACT_RENDER: begin
            expected_pixels.push_back(fetch_pixel(pix_in_i.pixel_x, pix_in_i.scan_line,
                                                  pix_in_i.mosaic_line_offset));
          end
          default: ;
        endcase
      end
      if (pix_out_i.valid && pix_out_i.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("result word with nothing expected", pix_out_i.colour, 0);
        end else begin
          want = expected_pixels.pop_front();
          if (pix_out_i.out_x !== want.x) begin
            report_mismatch("out_x", pix_out_i.out_x, want.x);
          end
          if (pix_out_i.colour !== want.colour) begin
            report_mismatch($sformatf("colour at x=%0d", want.x), pix_out_i.colour,
                            want.colour);
          end
          if (pix_out_i.transparent !== want.transparent) begin
            report_mismatch($sformatf("transparent at x=%0d", want.x),
                            pix_out_i.transparent, want.transparent);
          end
        end
      end
      pending_o <= expected_pixels.size();
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: bitmap background pixel fetch testbench
// Fills the palette, runs directed words for the edge cases of every mode,
// then randomized scanline runs under a series of register settings with
// idle bursts and a long result stall on the way. Every video halfword a
// render reads is written first. The checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bbpf_pkg::*;

  localparam int unsigned VIDEO_HALFWORDS = 49152;
  localparam int unsigned LINE_PIXELS     = 240;
  localparam int unsigned LONG_HOLD       = 64;
  localparam int unsigned SETTLE_CYCLES   = 12;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned PHASE_WORDS     = 18;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned dead_cycles;
  bit          no_idle;
  bit          hold_req;

  // stimulus-side view: which halfwords hold data, registers, column counter
  bit          vram_written [VIDEO_HALFWORDS];
  mode_e       cur_mode;
  logic        cur_page;
  logic        cur_mosaic;
  logic [4:0]  cur_width;
  logic [3:0]  mos_count;
  int unsigned words_sent;

  bbpf_in_if  pix_in ();
  bbpf_out_if pix_out ();
  bbpf_cfg_if reg_wr ();

  bitmap_background_pixel_fetch_core #(
    .VIDEO_HALFWORDS(VIDEO_HALFWORDS),
    .LINE_PIXELS    (LINE_PIXELS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pix_in),
    .cfg_i (reg_wr),
    .out_o (pix_out)
  );

  bbpf_colour_checker #(
    .VIDEO_HALFWORDS(VIDEO_HALFWORDS),
    .LINE_PIXELS    (LINE_PIXELS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_in_i    (pix_in),
    .reg_wr_i    (reg_wr),
    .pix_out_i   (pix_out),
    .fail_count_o(fail_count),
    .pending_o   (pending_words)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
        (reg_wr.valid && reg_wr.ready)) begin
      dead_cycles <= 0;
    end else if (rst_ni) begin
      dead_cycles <= dead_cycles + 1;
    end
    if (dead_cycles == STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // halfword a render word reads, or -1 when it reads none or reads as zero
  function automatic int fetch_slot(input logic [7:0] px, input logic [7:0] sl,
                                    input logic [3:0] loff);
    int unsigned line, sx, slot;
    line = sl;
    sx   = px;
    if (cur_mosaic) begin
      line = (loff > sl) ? 0 : sl - loff;
      sx   = (mos_count > px) ? 0 : px - mos_count;
    end
    case (cur_mode)
      MODE_DIRECT: slot = line * LINE_PIXELS + sx;
      MODE_PAL:    slot = (cur_page * PAGE_BYTES + line * LINE_PIXELS + sx) >> 1;
      MODE_SMALL: begin
        if (sx >= SMALL_W || line >= SMALL_H) begin
          return -1;
        end
        slot = (cur_page * PAGE_BYTES + line * SMALL_W * 2 + sx * 2) >> 1;
      end
      default: return -1;
    endcase
    if (slot >= VIDEO_HALFWORDS) begin
      return -1;
    end
    return int'(slot);
  endfunction

  task automatic push_word(input action_e act, input logic [15:0] addr,
                           input logic [15:0] data, input logic [7:0] px,
                           input logic [7:0] sl, input logic [3:0] loff);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      pix_in.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    pix_in.valid              <= 1'b1;
    pix_in.action             <= act;
    pix_in.address            <= addr;
    pix_in.write_data         <= data;
    pix_in.pixel_x            <= px;
    pix_in.scan_line          <= sl;
    pix_in.mosaic_line_offset <= loff;
    do @(posedge clk_i); while (!pix_in.ready);
    if (act != ACT_NONE) begin
      words_sent++;
    end
  endtask

  // memory write or ignored word, pixel fields random
  task automatic poke(input action_e act, input logic [15:0] addr, input logic [15:0] data);
    push_word(act, addr, data, 8'($urandom), 8'($urandom), 4'($urandom));
    if (act == ACT_VWRITE && addr < VIDEO_HALFWORDS) begin
      vram_written[addr] = 1'b1;
    end
  endtask

  task automatic draw(input logic [7:0] px, input logic [7:0] sl, input logic [3:0] loff);
    int          slot;
    int unsigned span;
    if (px == 8'd0) begin
      mos_count = 4'd0;
    end
    slot = fetch_slot(px, sl, loff);
    if (slot >= 0 && !vram_written[slot]) begin
      poke(ACT_VWRITE, 16'(slot), 16'($urandom));
    end
    push_word(ACT_RENDER, 16'($urandom), 16'($urandom), px, sl, loff);
    if (cur_mosaic) begin
      span = (cur_width == 5'd0) ? 1 : (cur_width > MOSAIC_MAX) ? MOSAIC_MAX : cur_width;
      mos_count = (mos_count + 1 >= span) ? 4'd0 : mos_count + 4'd1;
    end
  endtask

  // drain: no result outstanding, then let trailing writes leave the pipe
  task automatic settle();
    pix_in.valid <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_word(input reg_e idx, input logic [7:0] data);
    reg_wr.valid <= 1'b1;
    reg_wr.index <= idx;
    reg_wr.data  <= data;
    do @(posedge clk_i); while (!reg_wr.ready);
  endtask

  // unused upper data bits are random
  task automatic set_config(input mode_e mode, input logic page, input logic mos,
                            input logic [4:0] width);
    settle();
    reg_word(REG_MODE, {6'($urandom), mode});
    reg_word(REG_PAGE, {7'($urandom), page});
    reg_word(REG_MOSAIC, {7'($urandom), mos});
    reg_word(REG_MOSAIC_W, {3'($urandom), width});
    reg_wr.valid <= 1'b0;
    cur_mode   = mode;
    cur_page   = page;
    cur_mosaic = mos;
    cur_width  = width;
  endtask

  initial begin : result_sink
    int unsigned n;
    pix_out.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // hold off long enough for the queue to fill and stall the input
        pix_out.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
        pix_out.ready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        pix_out.ready <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned budget, run_len;
    logic [7:0]  sl, start;
    logic [3:0]  loff;
    logic [4:0]  width;
    rst_ni                    = 1'b0;
    pix_in.valid              = 1'b0;
    pix_in.action             = ACT_NONE;
    pix_in.address            = 16'h0000;
    pix_in.write_data         = 16'h0000;
    pix_in.pixel_x            = 8'd0;
    pix_in.scan_line          = 8'd0;
    pix_in.mosaic_line_offset = 4'd0;
    reg_wr.valid              = 1'b0;
    reg_wr.index              = REG_MODE;
    reg_wr.data               = 8'd0;
    cur_mode                  = MODE_DIRECT;
    cur_page                  = 1'b0;
    cur_mosaic                = 1'b0;
    cur_width                 = 5'd1;
    mos_count                 = 4'd0;
    words_sent                = 0;
    no_idle                   = 1'b0;
    hold_req                  = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // whole palette first, so any index a paletted pixel yields is defined
    for (int i = 0; i < PAL_DEPTH; i++) begin
      poke(ACT_PWRITE, 16'(i), 16'($urandom));
    end

    // directed: ignored words, out-of-range writes, corners of each mode
    poke(ACT_NONE, 16'hFFFF, 16'hFFFF);
    poke(ACT_VWRITE, 16'hFFFF, 16'hFFFF);
    poke(ACT_VWRITE, 16'(VIDEO_HALFWORDS), 16'h0000);
    poke(ACT_PWRITE, 16'(PAL_DEPTH), 16'hFFFF);
    draw(0, 0, 0);
    draw(239, 159, 0);
    draw(255, 255, 15);
    set_config(MODE_PAL, 1'b1, 1'b0, 5'd1);
    draw(1, 0, 0);
    draw(0, 0, 0);
    draw(255, 255, 15);
    set_config(MODE_SMALL, 1'b1, 1'b0, 5'd1);
    draw(159, 127, 0);
    draw(160, 0, 0);
    draw(0, 128, 0);
    set_config(MODE_BLANK, 1'b0, 1'b0, 5'd1);
    draw(5, 5, 5);
    set_config(MODE_DIRECT, 1'b0, 1'b1, 5'd0);
    draw(0, 20, 3);
    draw(1, 20, 3);
    draw(2, 2, 9);
    set_config(MODE_DIRECT, 1'b0, 1'b1, 5'd31);
    draw(0, 7, 0);
    draw(1, 7, 0);
    // counter runs ahead of the column when a run jumps back
    set_config(MODE_PAL, 1'b0, 1'b1, 5'd4);
    draw(0, 9, 1);
    draw(1, 9, 1);
    draw(2, 9, 1);
    draw(1, 9, 1);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       width = 5'd1;
        1:       width = 5'd16;
        2:       width = 5'd0;
        3:       width = 5'd31;
        default: width = 5'($urandom_range(1, 16));
      endcase
      set_config((p == 5) ? MODE_BLANK : mode_e'(p % 3), 1'($urandom), !(p == 0 || p == 4),
                 width);
      no_idle = (p == PHASES - 1);
      if (p == 2) begin
        hold_req = 1'b1;
      end
      budget = words_sent + PHASE_WORDS;
      while (words_sent < budget) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            sl      = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 159));
            loff    = 4'($urandom);
            start   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0;
            run_len = $urandom_range(1, 24);
            for (int k = 0; k < run_len && start + k < 256 && words_sent < budget; k++) begin
              draw(8'(start + k), sl, loff);
            end
          end
          6: poke(ACT_VWRITE, 16'($urandom), 16'($urandom));
          7: poke(ACT_PWRITE, ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 511))
                                                          : 16'($urandom), 16'($urandom));
          8: poke(ACT_NONE, 16'($urandom), 16'($urandom));
          default: draw(8'($urandom), 8'($urandom), 4'($urandom));
        endcase
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
